>>> src/stx_lfr_pkg.sv
// ----------------------------------------------------------------------------
// stx_lfr_pkg
// Shared types and constants of the start / length / end frame receiver.
// ----------------------------------------------------------------------------
package stx_lfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int NUM_DATA   = 8;
  // bytes read out of a frame: the command then the data bytes
  localparam int FIRST_KEPT = 2;
  localparam int NUM_KEPT   = NUM_DATA + 1;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h02;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h03;

  typedef enum logic {
    CFG_START_BYTE,
    CFG_END_BYTE
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              rx_error;
  } item_t;

  typedef struct packed {
    logic                             frame_ok;
    logic [BYTE_W-1:0]                command;
    logic [NUM_DATA-1:0][BYTE_W-1:0] data;
  } res_t;

endpackage

>>> src/stx_lfr_ifs.sv
// ----------------------------------------------------------------------------
// stx_lfr_ifs
// Valid / ready channels for received bytes and decoded frames.
// ----------------------------------------------------------------------------
interface stx_lfr_rx_if import stx_lfr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_error;

  modport source (output valid, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

interface stx_lfr_res_if import stx_lfr_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              frame_ok;
  logic [BYTE_W-1:0] command;
  logic [BYTE_W-1:0] data0;
  logic [BYTE_W-1:0] data1;
  logic [BYTE_W-1:0] data2;
  logic [BYTE_W-1:0] data3;
  logic [BYTE_W-1:0] data4;
  logic [BYTE_W-1:0] data5;
  logic [BYTE_W-1:0] data6;
  logic [BYTE_W-1:0] data7;

  modport source (output valid, output frame_ok, output command,
                  output data0, output data1, output data2, output data3,
                  output data4, output data5, output data6, output data7,
                  input ready);
  modport sink   (input valid, input frame_ok, input command,
                  input data0, input data1, input data2, input data3,
                  input data4, input data5, input data6, input data7,
                  output ready);
endinterface

>>> src/stx_length_frame_receiver.sv
// The last byte of a frame passes the input register, then the result register.
// Throughput: one byte per cycle; the input register, decode and result register
// form a two-stage pipeline that only stalls while a result waits to be taken.
// Reset (synchronous, rst_n low): index and length to zero, both stages empty,
// start byte to 0x02 and end byte to 0x03. The byte store is not cleared.
// ----------------------------------------------------------------------------
// stx_length_frame_receiver
// Start / length / end framed byte receiver with a frame result channel.
// ----------------------------------------------------------------------------
module stx_length_frame_receiver import stx_lfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 16,
  parameter int FRAME_LENGTH = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  stx_lfr_rx_if.sink        in_chan,
  stx_lfr_res_if.source     out_chan,
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_index,
  input  logic [BYTE_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  s_valid_r;
  item_t s_item_r;
  logic  s_adv;
  logic  emit;
  logic  out_free;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= START_BYTE_RST;
      cfg_r.end_byte   <= END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: cfg_r.start_byte <= cfg_data;
        CFG_END_BYTE:   cfg_r.end_byte   <= cfg_data;
      endcase
    end
  end

  // a byte that yields no result never waits on the output side
  assign s_adv         = s_valid_r && (!emit || out_free);
  assign in_chan.ready = !s_valid_r || s_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s_item_r.rx_byte  <= in_chan.rx_byte;
      s_item_r.rx_error <= in_chan.rx_error;
    end
  end

  stx_lfr_tracker #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s_adv),
    .item    (s_item_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .res     (res)
  );

  stx_lfr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s_adv && emit),
    .res      (res),
    .out_free (out_free),
    .out_chan (out_chan)
  );

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r && !s_adv |-> !in_chan.ready)
    else $error("input stage overwritten while stalled");

endmodule

>>> src/stx_lfr_tracker.sv
// ----------------------------------------------------------------------------
// stx_lfr_tracker
// Frame position, length and byte store; decodes one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
module stx_lfr_tracker import stx_lfr_pkg::*; #(
  parameter int BUFFER_DEPTH = 16,
  parameter int FRAME_LENGTH = 13
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output logic  emit,
  output res_t  res
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH + 1);

  logic [IDX_W-1:0]                 idx_r;
  logic [IDX_W-1:0]                 idx_nxt;
  logic [BYTE_W-1:0]                len_r;
  logic [BYTE_W-1:0]                len_nxt;
  logic [NUM_KEPT-1:0][BYTE_W-1:0] kept_r;
  logic [BYTE_W:0]                  idx_inc;
  logic                             store_en;
  logic                             frame_ok;

  assign idx_inc = {{(BYTE_W + 1 - IDX_W){1'b0}}, idx_r} + (BYTE_W + 1)'(1);

  always_comb begin
    idx_nxt  = idx_r;
    len_nxt  = len_r;
    store_en = 1'b0;
    emit     = 1'b0;
    priority if (idx_r == IDX_W'(0)) begin
      if (item.rx_byte == cfg.start_byte) idx_nxt = IDX_W'(1);
    end else if (idx_r == IDX_W'(1)) begin
      len_nxt = item.rx_byte;
      idx_nxt = IDX_W'(2);
    end else if (idx_r >= IDX_W'(BUFFER_DEPTH)) begin
      // buffer full: drop the byte and start over
      idx_nxt = IDX_W'(0);
    end else if (idx_inc == {1'b0, len_r}) begin
      store_en = 1'b1;
      emit     = 1'b1;
      idx_nxt  = IDX_W'(0);
    end else begin
      store_en = 1'b1;
      idx_nxt  = item.rx_error ? IDX_W'(0) : idx_r + IDX_W'(1);
    end
  end

  assign frame_ok = (len_r == BYTE_W'(FRAME_LENGTH)) && (item.rx_byte == cfg.end_byte);

  always_comb begin
    res.frame_ok = frame_ok;
    res.command  = frame_ok ? kept_r[0] : '0;
    for (int j = 0; j < NUM_DATA; j++) begin
      res.data[j] = frame_ok ? kept_r[j + 1] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      len_r <= '0;
    end else if (advance) begin
      idx_r <= idx_nxt;
      len_r <= len_nxt;
    end
  end

  // only the command and data positions are ever read back
  for (genvar k = 0; k < NUM_KEPT; k++) begin : g_kept
    always_ff @(posedge clk) begin
      if (advance && store_en && idx_r == IDX_W'(k + FIRST_KEPT)) begin
        kept_r[k] <= item.rx_byte;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(BUFFER_DEPTH))
    else $error("frame index beyond buffer depth");

  a_emit_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    advance && emit |=> idx_r == IDX_W'(0))
    else $error("index not rewound after a completed frame");

  a_bad_frame_blank: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !res.frame_ok |-> res.command == '0 && res.data == '0)
    else $error("rejected frame carries payload");

endmodule

>>> src/stx_lfr_out_reg.sv
// ----------------------------------------------------------------------------
// stx_lfr_out_reg
// Result register that drives the frame channel.
// ----------------------------------------------------------------------------
module stx_lfr_out_reg import stx_lfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic out_free,
  stx_lfr_res_if.source out_chan
);

  logic valid_r;
  res_t res_r;

  assign out_free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid    = valid_r;
  assign out_chan.frame_ok = res_r.frame_ok;
  assign out_chan.command  = res_r.command;
  assign out_chan.data0    = res_r.data[0];
  assign out_chan.data1    = res_r.data[1];
  assign out_chan.data2    = res_r.data[2];
  assign out_chan.data3    = res_r.data[3];
  assign out_chan.data4    = res_r.data[4];
  assign out_chan.data5    = res_r.data[5];
  assign out_chan.data6    = res_r.data[6];
  assign out_chan.data7    = res_r.data[7];

endmodule
